[rtl/olfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package olfp_pkg;

  // Field and state widths
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned X_W       = 16;
  localparam int unsigned Y_W       = 20;
  localparam int unsigned SX_W      = 33;
  localparam int unsigned SY_W      = 37;
  localparam int unsigned SXX_W     = 49;
  localparam int unsigned SXY_W     = 53;
  localparam int unsigned FIT_W     = 48;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned STAT_W    = 3;

  localparam logic [CNT_W-1:0] MAX_POINTS  = CNT_W'(65536);
  localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(2);

  // Serial multiplier: a operand, b operand (scanned), product
  localparam int unsigned MA_W = 53;
  localparam int unsigned MB_W = 37;
  localparam int unsigned MP_W = MA_W + MB_W;

  // Serial divider: denominator and numerators
  localparam int unsigned DEN_W  = 66;
  localparam int unsigned PNUM_W = 70;
  localparam int unsigned QNUM_W = 86;
  localparam int unsigned NUM_W  = QNUM_W + FRAC_BITS;
  localparam int unsigned DCNT_W = $clog2(NUM_W + 1);

  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_PREDICT = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_SEED  = 3'd1,
    STAT_DROP  = 3'd2,
    STAT_RESET = 3'd3,
    STAT_DEGEN = 3'd4,
    STAT_FULL  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MLOAD,
    S_MWAIT,
    S_DLOAD,
    S_DWAIT,
    S_DONE
  } fsm_e;

  // Products taken in turn by the shared multiplier
  typedef enum logic [2:0] {
    MS_PRED,
    MS_NXX,
    MS_SXSX,
    MS_NXY,
    MS_SXSY,
    MS_SYXX,
    MS_SXXY
  } mstep_e;

endpackage

`default_nettype wire

[rtl/olfp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Request channel
interface olfp_in_if;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [olfp_pkg::X_W-1:0] token_count;
  logic [olfp_pkg::Y_W-1:0] exec_time;

  modport source (output valid, operation, token_count, exec_time, input ready);
  modport sink   (input valid, operation, token_count, exec_time, output ready);
endinterface

// Result channel
interface olfp_out_if;
  logic                        valid;
  logic                        ready;
  logic [olfp_pkg::TIME_W-1:0] predicted_time;
  logic [olfp_pkg::STAT_W-1:0] status;

  modport source (output valid, predicted_time, status, input ready);
  modport sink   (input valid, predicted_time, status, output ready);
endinterface

`default_nettype wire

[rtl/olfp_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiplier, one bit of b per cycle, stops once b runs out of ones
module olfp_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [olfp_pkg::MA_W-1:0]   a_i,
  input  logic [olfp_pkg::MB_W-1:0]   b_i,
  output logic                        done_o,
  output logic [olfp_pkg::MP_W-1:0]   p_o
);

  logic                      run_q;
  logic [olfp_pkg::MP_W-1:0] a_q;
  logic [olfp_pkg::MP_W-1:0] p_q;
  logic [olfp_pkg::MB_W-1:0] b_q;
  logic                      b_empty;

  assign b_empty = (b_q == '0);
  assign done_o  = run_q && b_empty;
  assign p_o     = p_q;

  // busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (done_o) begin
      run_q <= 1'b0;
    end
  end

  // operand shifters and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= olfp_pkg::MP_W'(a_i);
      b_q <= b_i;
      p_q <= '0;
    end else if (run_q && !b_empty) begin
      if (b_q[0]) begin
        p_q <= p_q + a_q;
      end
      a_q <= {a_q[olfp_pkg::MP_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[olfp_pkg::MB_W-1:1]};
    end
  end

endmodule

`default_nettype wire

[rtl/olfp_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle; quotient saturates to 48 bits
module olfp_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [olfp_pkg::NUM_W-1:0]   num_i,
  input  logic [olfp_pkg::DEN_W-1:0]   den_i,
  output logic                         done_o,
  output logic [olfp_pkg::FIT_W-1:0]   quo_o
);

  logic                        run_q;
  logic [olfp_pkg::DCNT_W-1:0] cnt_q;
  logic [olfp_pkg::NUM_W-1:0]  num_q;
  logic [olfp_pkg::DEN_W-1:0]  den_q;
  logic [olfp_pkg::DEN_W-1:0]  rem_q;
  logic [olfp_pkg::FIT_W-1:0]  quo_q;
  logic                        ovf_q;
  logic [olfp_pkg::DEN_W:0]    rem_sh;
  logic [olfp_pkg::DEN_W+1:0]  diff;
  logic                        fits;

  assign done_o = run_q && (cnt_q == '0);
  assign quo_o  = ovf_q ? '1 : quo_q;

  // trial subtract
  always_comb begin
    rem_sh = {rem_q, num_q[olfp_pkg::NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    fits   = !diff[olfp_pkg::DEN_W+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= olfp_pkg::DCNT_W'(olfp_pkg::NUM_W);
    end else if (done_o) begin
      run_q <= 1'b0;
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (run_q && (cnt_q != '0)) begin
      num_q <= {num_q[olfp_pkg::NUM_W-2:0], 1'b0};
      rem_q <= fits ? diff[olfp_pkg::DEN_W-1:0] : rem_sh[olfp_pkg::DEN_W-1:0];
      quo_q <= {quo_q[olfp_pkg::FIT_W-2:0], fits};
      ovf_q <= ovf_q | quo_q[olfp_pkg::FIT_W-1];
    end
  end

endmodule

`default_nettype wire

[rtl/online_linear_fit_predictor_unit.sv]
// Running least-squares line fit of execution time against token count. An add
// word (operation 0) folds a measured point into the fit; a predict word
// (operation 1) returns slope*tokens+intercept in unsigned Q32.16, saturating.
// One word is worked on at a time. Full and first-point adds skip the
// multiplier; a predict runs one product. A fitted add runs six products
// through one shift-add multiplier that retires one multiplier bit per cycle
// (n twice, Sx three times, Sy once), then two restoring dividers in
// parallel; a rejected point skips the division. The result register lets
// a finished word wait on the output while the next word is taken in.
`timescale 1ns / 1ps
`default_nettype none

module online_linear_fit_predictor_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  olfp_in_if.sink    in_i,
  olfp_out_if.source out_o
);

  olfp_pkg::fsm_e   state_q, state_d;
  olfp_pkg::mstep_e step_q, step_nxt;

  // fit state
  logic [olfp_pkg::CNT_W-1:0] count_q;
  logic [olfp_pkg::SX_W-1:0]  sx_q;
  logic [olfp_pkg::SY_W-1:0]  sy_q;
  logic [olfp_pkg::SXX_W-1:0] sxx_q;
  logic [olfp_pkg::SXY_W-1:0] sxy_q;
  logic [olfp_pkg::FIT_W-1:0] slope_q;
  logic [olfp_pkg::FIT_W-1:0] icpt_q;

  // working registers for one word
  logic [olfp_pkg::X_W-1:0]    x_q;
  logic [olfp_pkg::CNT_W-1:0]  n_q;
  logic [olfp_pkg::SX_W-1:0]   nsx_q;
  logic [olfp_pkg::SY_W-1:0]   nsy_q;
  logic [olfp_pkg::SXX_W-1:0]  nsxx_q;
  logic [olfp_pkg::SXY_W-1:0]  nsxy_q;
  logic [olfp_pkg::MP_W-1:0]   pa_q;
  logic [olfp_pkg::DEN_W-1:0]  den_q;
  logic [olfp_pkg::PNUM_W-1:0] pnum_q;
  logic [olfp_pkg::QNUM_W-1:0] qnum_q;
  logic                        ppos_q;

  // pending and output result
  logic [olfp_pkg::TIME_W-1:0] res_time_q;
  olfp_pkg::status_e           res_stat_q;
  logic                        out_v_q;
  logic [olfp_pkg::TIME_W-1:0] out_time_q;
  olfp_pkg::status_e           out_stat_q;

  logic accept, in_rdy, mul_start, div_start, out_load;
  logic is_full, is_empty;
  logic [2*olfp_pkg::X_W-1:0]         xx;
  logic [olfp_pkg::X_W+olfp_pkg::Y_W-1:0] xy;

  logic [olfp_pkg::MA_W-1:0]   mul_a;
  logic [olfp_pkg::MB_W-1:0]   mul_b;
  logic                        mul_done;
  logic [olfp_pkg::MP_W-1:0]   mul_p;
  logic                        p_gt;
  logic [olfp_pkg::MP_W-1:0]   p_sub;
  logic                        fit_ok;
  logic [olfp_pkg::TIME_W:0]   pred_sum;
  logic [olfp_pkg::TIME_W-1:0] pred_val;

  logic                        div_done_s, div_done_i;
  logic [olfp_pkg::FIT_W-1:0]  quo_s, quo_i;

  assign accept   = in_i.valid && in_rdy;
  assign in_i.ready = in_rdy;
  assign is_full  = (count_q >= olfp_pkg::MAX_POINTS);
  assign is_empty = (count_q == '0);
  assign xx       = in_i.token_count * in_i.token_count;
  assign xy       = in_i.token_count * in_i.exec_time;

  assign out_o.valid          = out_v_q;
  assign out_o.predicted_time = out_time_q;
  assign out_o.status         = out_stat_q;

  // multiplier operand select
  always_comb begin
    case (step_q)
      olfp_pkg::MS_PRED: begin
        mul_a = olfp_pkg::MA_W'(slope_q);
        mul_b = olfp_pkg::MB_W'(x_q);
      end
      olfp_pkg::MS_NXX: begin
        mul_a = olfp_pkg::MA_W'(nsxx_q);
        mul_b = olfp_pkg::MB_W'(n_q);
      end
      olfp_pkg::MS_SXSX: begin
        mul_a = olfp_pkg::MA_W'(nsx_q);
        mul_b = olfp_pkg::MB_W'(nsx_q);
      end
      olfp_pkg::MS_NXY: begin
        mul_a = nsxy_q;
        mul_b = olfp_pkg::MB_W'(n_q);
      end
      olfp_pkg::MS_SXSY: begin
        mul_a = olfp_pkg::MA_W'(nsy_q);
        mul_b = olfp_pkg::MB_W'(nsx_q);
      end
      olfp_pkg::MS_SYXX: begin
        mul_a = olfp_pkg::MA_W'(nsxx_q);
        mul_b = nsy_q;
      end
      olfp_pkg::MS_SXXY: begin
        mul_a = nsxy_q;
        mul_b = olfp_pkg::MB_W'(nsx_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // step order
  always_comb begin
    case (step_q)
      olfp_pkg::MS_NXX:  step_nxt = olfp_pkg::MS_SXSX;
      olfp_pkg::MS_SXSX: step_nxt = olfp_pkg::MS_NXY;
      olfp_pkg::MS_NXY:  step_nxt = olfp_pkg::MS_SXSY;
      olfp_pkg::MS_SXSY: step_nxt = olfp_pkg::MS_SYXX;
      olfp_pkg::MS_SYXX: step_nxt = olfp_pkg::MS_SXXY;
      default:           step_nxt = olfp_pkg::MS_PRED;
    endcase
  end

  // compare held product against the fresh one; predict saturation
  always_comb begin
    p_gt     = (pa_q > mul_p);
    p_sub    = pa_q - mul_p;
    fit_ok   = ppos_q && p_gt;
    pred_sum = {1'b0, mul_p[olfp_pkg::TIME_W-1:0]} + {1'b0, icpt_q};
    if ((|mul_p[olfp_pkg::MP_W-1:olfp_pkg::TIME_W]) || pred_sum[olfp_pkg::TIME_W]) begin
      pred_val = '1;
    end else begin
      pred_val = pred_sum[olfp_pkg::TIME_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      olfp_pkg::S_IDLE: begin
        if (accept) begin
          if (in_i.operation == olfp_pkg::OP_PREDICT) begin
            state_d = olfp_pkg::S_MLOAD;
          end else if (is_full || is_empty) begin
            state_d = olfp_pkg::S_DONE;
          end else begin
            state_d = olfp_pkg::S_MLOAD;
          end
        end
      end
      olfp_pkg::S_MLOAD: state_d = olfp_pkg::S_MWAIT;
      olfp_pkg::S_MWAIT: begin
        if (mul_done) begin
          case (step_q)
            olfp_pkg::MS_PRED: state_d = olfp_pkg::S_DONE;
            olfp_pkg::MS_SXSX: state_d = p_gt ? olfp_pkg::S_MLOAD : olfp_pkg::S_DONE;
            olfp_pkg::MS_SXXY: state_d = fit_ok ? olfp_pkg::S_DLOAD : olfp_pkg::S_DONE;
            default:           state_d = olfp_pkg::S_MLOAD;
          endcase
        end
      end
      olfp_pkg::S_DLOAD: state_d = olfp_pkg::S_DWAIT;
      olfp_pkg::S_DWAIT: begin
        if (div_done_s) begin
          state_d = olfp_pkg::S_DONE;
        end
      end
      olfp_pkg::S_DONE: begin
        if (out_load) begin
          state_d = olfp_pkg::S_IDLE;
        end
      end
      default: state_d = olfp_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_rdy    = (state_q == olfp_pkg::S_IDLE);
    mul_start = (state_q == olfp_pkg::S_MLOAD);
    div_start = (state_q == olfp_pkg::S_DLOAD);
    out_load  = (state_q == olfp_pkg::S_DONE) && (!out_v_q || out_o.ready);
  end

  // control state and fit state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olfp_pkg::S_IDLE;
      step_q  <= olfp_pkg::MS_PRED;
      count_q <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      sxx_q   <= '0;
      sxy_q   <= '0;
      slope_q <= '0;
      icpt_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (accept) begin
        step_q <= (in_i.operation == olfp_pkg::OP_PREDICT) ? olfp_pkg::MS_PRED
                                                           : olfp_pkg::MS_NXX;
        // first point seeds the sums
        if ((in_i.operation == olfp_pkg::OP_ADD) && !is_full && is_empty) begin
          count_q <= olfp_pkg::CNT_W'(1);
          sx_q    <= olfp_pkg::SX_W'(in_i.token_count);
          sy_q    <= olfp_pkg::SY_W'(in_i.exec_time);
          sxx_q   <= olfp_pkg::SXX_W'(xx);
          sxy_q   <= olfp_pkg::SXY_W'(xy);
        end
      end else if ((state_q == olfp_pkg::S_MWAIT) && mul_done) begin
        step_q <= step_nxt;
        if ((step_q == olfp_pkg::MS_SXSX) && !p_gt) begin
          count_q <= n_q;
        end
        if ((step_q == olfp_pkg::MS_SXXY) && !fit_ok && (n_q == olfp_pkg::RESET_COUNT)) begin
          count_q <= '0;
          sx_q    <= '0;
          sy_q    <= '0;
          sxx_q   <= '0;
          sxy_q   <= '0;
        end
      end else if ((state_q == olfp_pkg::S_DWAIT) && div_done_s) begin
        slope_q <= quo_s;
        icpt_q  <= quo_i;
        count_q <= n_q;
        sx_q    <= nsx_q;
        sy_q    <= nsy_q;
        sxx_q   <= nsxx_q;
        sxy_q   <= nsxy_q;
      end

      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // word payload, products, pending result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q        <= in_i.token_count;
      n_q        <= count_q + 1'b1;
      nsx_q      <= sx_q + olfp_pkg::SX_W'(in_i.token_count);
      nsy_q      <= sy_q + olfp_pkg::SY_W'(in_i.exec_time);
      nsxx_q     <= sxx_q + olfp_pkg::SXX_W'(xx);
      nsxy_q     <= sxy_q + olfp_pkg::SXY_W'(xy);
      res_time_q <= '0;
      res_stat_q <= is_full ? olfp_pkg::STAT_FULL : olfp_pkg::STAT_SEED;
    end else if ((state_q == olfp_pkg::S_MWAIT) && mul_done) begin
      case (step_q)
        olfp_pkg::MS_PRED: begin
          res_time_q <= pred_val;
          res_stat_q <= olfp_pkg::STAT_OK;
        end
        olfp_pkg::MS_SXSX: begin
          den_q      <= p_sub[olfp_pkg::DEN_W-1:0];
          res_stat_q <= olfp_pkg::STAT_DEGEN;
        end
        olfp_pkg::MS_SXSY: begin
          ppos_q <= p_gt;
          pnum_q <= p_sub[olfp_pkg::PNUM_W-1:0];
        end
        olfp_pkg::MS_SXXY: begin
          qnum_q     <= p_sub[olfp_pkg::QNUM_W-1:0];
          res_stat_q <= fit_ok ? olfp_pkg::STAT_OK :
                        (n_q == olfp_pkg::RESET_COUNT) ? olfp_pkg::STAT_RESET
                                                       : olfp_pkg::STAT_DROP;
        end
        default: begin
          pa_q <= mul_p;
        end
      endcase
    end
    if (out_load) begin
      out_time_q <= res_time_q;
      out_stat_q <= res_stat_q;
    end
  end

  olfp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // slope and intercept divide together over the same denominator
  olfp_div u_div_slope (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (olfp_pkg::NUM_W'({pnum_q, {olfp_pkg::FRAC_BITS{1'b0}}})),
    .den_i   (den_q),
    .done_o  (div_done_s),
    .quo_o   (quo_s)
  );

  olfp_div u_div_icpt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({qnum_q, {olfp_pkg::FRAC_BITS{1'b0}}}),
    .den_i   (den_q),
    .done_o  (div_done_i),
    .quo_o   (quo_i)
  );

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_rdy)
    else $error("input taken while a word is in flight");

  a_divs_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_s == div_done_i)
    else $error("dividers out of step");

  a_mul_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == olfp_pkg::S_MWAIT))
    else $error("multiplier finished outside its wait state");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= olfp_pkg::MAX_POINTS)
    else $error("point count beyond limit");

  a_add_zero_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_stat_q != olfp_pkg::STAT_OK)) |-> (out_time_q == '0))
    else $error("nonzero time on an add word");

endmodule

`default_nettype wire

[tb/sv/tb_online_linear_fit_predictor_unit.sv]
`timescale 1ns / 1ps

module tb_online_linear_fit_predictor_unit;
  import olfp_pkg::*;

  typedef struct packed {
    logic              operation;
    logic [X_W-1:0]    token_count;
    logic [Y_W-1:0]    exec_time;
  } fit_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] predicted_time;
    status_e           status;
  } fit_rsp_t;

  localparam int unsigned END_WAIT    = 400;
  localparam longint      CYCLE_LIMIT = 64'd3_000_000;

  logic clk_i;
  logic rst_ni;

  olfp_in_if  req_if ();
  olfp_out_if rsp_if ();

  online_linear_fit_predictor_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // Predictor state
  logic [CNT_W-1:0]  fit_cnt;
  logic [SX_W-1:0]   fit_sx;
  logic [SY_W-1:0]   fit_sy;
  logic [SXX_W-1:0]  fit_sxx;
  logic [SXY_W-1:0]  fit_sxy;
  logic [FIT_W-1:0]  fit_slope;
  logic [FIT_W-1:0]  fit_icpt;

  fit_req_t req_q[$];
  fit_rsp_t rsp_expected_q[$];

  int     err_cnt;
  int     rsp_cnt;
  int     stat_seen[6];
  bit     idle_off;
  bit     stim_done;
  longint cycle_cnt;
  int     drv_gap;
  int     mon_gap;

  // floor((num << FRAC_BITS) / den), clamped to 48 bits
  function automatic logic [FIT_W-1:0] fix_quotient(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    q = (num << FRAC_BITS) / den;
    return (q > {{80{1'b0}}, {FIT_W{1'b1}}}) ? {FIT_W{1'b1}} : q[FIT_W-1:0];
  endfunction

  // Expected answer for one word; updates the fit
  function automatic fit_rsp_t fit_apply(fit_req_t r);
    fit_rsp_t     o;
    logic [127:0] x, y, n, sx, sy, sxx, sxy, a, b, c, d, prod, sum;
    o.predicted_time = '0;
    x = 128'(r.token_count);
    y = 128'(r.exec_time);
    if (r.operation == OP_PREDICT) begin
      prod = 128'(fit_slope) * x;
      sum  = prod + 128'(fit_icpt);
      o.predicted_time = (sum > 128'hFFFF_FFFF_FFFF) ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      o.status = STAT_OK;
      return o;
    end
    if (fit_cnt >= MAX_POINTS) begin
      o.status = STAT_FULL;
      return o;
    end
    n = 128'(fit_cnt) + 128'd1;
    if (n == 128'd1) begin
      fit_cnt = CNT_W'(1);
      fit_sx  = SX_W'(x);
      fit_sy  = SY_W'(y);
      fit_sxx = SXX_W'(x * x);
      fit_sxy = SXY_W'(x * y);
      o.status = STAT_SEED;
      return o;
    end
    sx  = 128'(fit_sx) + x;
    sy  = 128'(fit_sy) + y;
    sxx = 128'(fit_sxx) + x * x;
    sxy = 128'(fit_sxy) + x * y;
    a = n * sxx;
    b = sx * sx;
    if (a <= b) begin
      fit_cnt = CNT_W'(n);
      o.status = STAT_DEGEN;
      return o;
    end
    d = a - b;
    a = n * sxy;
    b = sx * sy;
    c = sy * sxx;
    if (a > b && c > sx * sxy) begin
      fit_slope = fix_quotient(a - b, d);
      fit_icpt  = fix_quotient(c - sx * sxy, d);
      fit_cnt = CNT_W'(n);
      fit_sx  = SX_W'(sx);
      fit_sy  = SY_W'(sy);
      fit_sxx = SXX_W'(sxx);
      fit_sxy = SXY_W'(sxy);
      o.status = STAT_OK;
    end else if (n == 128'(RESET_COUNT)) begin
      fit_cnt = '0;
      fit_sx  = '0;
      fit_sy  = '0;
      fit_sxx = '0;
      fit_sxy = '0;
      o.status = STAT_RESET;
    end else begin
      o.status = STAT_DROP;
    end
    return o;
  endfunction

  function automatic fit_req_t mk_req(logic op, int unsigned tok, int unsigned tim);
    fit_req_t r;
    r.operation   = op;
    r.token_count = tok[X_W-1:0];
    r.exec_time   = tim[Y_W-1:0];
    return r;
  endfunction

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Stimulus
  initial begin
    int unsigned base, slope, tok;
    stim_done = 1'b0;
    idle_off  = 1'b0;
    // directed: empty fit, seed, reset, degenerate, drop, extremes
    req_q.push_back(mk_req(OP_PREDICT, 65535, 0));
    req_q.push_back(mk_req(OP_ADD, 100, 1000));
    req_q.push_back(mk_req(OP_ADD, 200, 500));    // negative slope: reset
    req_q.push_back(mk_req(OP_ADD, 100, 1000));
    req_q.push_back(mk_req(OP_ADD, 100, 2000));   // same x: degenerate
    req_q.push_back(mk_req(OP_ADD, 200, 3000));
    req_q.push_back(mk_req(OP_ADD, 300, 100));    // drop
    req_q.push_back(mk_req(OP_PREDICT, 0, 1048575));
    req_q.push_back(mk_req(OP_PREDICT, 65535, 0));
    req_q.push_back(mk_req(OP_ADD, 0, 0));
    req_q.push_back(mk_req(OP_ADD, 65535, 1048575));
    req_q.push_back(mk_req(OP_PREDICT, 65535, 1048575));
    req_q.push_back(mk_req(OP_ADD, 1, 1));
    req_q.push_back(mk_req(OP_PREDICT, 1, 0));
    // random: mostly near-linear point streams, some noise, predicts mixed in
    while (req_q.size() < 820) begin
      base  = $urandom_range(1, 5000);
      slope = $urandom_range(1, 15);
      repeat ($urandom_range(2, 12)) begin
        tok = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 60000);
        if ($urandom_range(0, 4) == 0)
          req_q.push_back(mk_req(OP_ADD, tok, $urandom));
        else
          req_q.push_back(mk_req(OP_ADD, tok, base + slope * (tok & 16'hFFFF) +
                                 $urandom_range(0, 40)));
        if ($urandom_range(0, 2) == 0)
          req_q.push_back(mk_req(OP_PREDICT, $urandom, $urandom));
      end
    end
    wait (req_q.size() == 0);
    stim_done = 1'b1;
  end

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.operation   <= OP_ADD;
      req_if.token_count <= '0;
      req_if.exec_time   <= '0;
      drv_gap            <= 0;
      idle_off           <= 1'b0;
    end else begin
      if (req_q.size() < 60) idle_off <= 1'b1;
      if (req_if.valid && req_if.ready) begin
        rsp_expected_q.push_back(fit_apply({req_if.operation, req_if.token_count,
                                            req_if.exec_time}));
      end
      if (!req_if.valid || req_if.ready) begin
        if (drv_gap > 0) begin
          drv_gap      <= drv_gap - 1;
          req_if.valid <= 1'b0;
        end else if (!idle_off && $urandom_range(0, 3) == 0) begin
          drv_gap      <= $urandom_range(0, 4);
          req_if.valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          {req_if.operation, req_if.token_count, req_if.exec_time} <= req_q.pop_front();
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    fit_rsp_t exp_rsp;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      mon_gap      <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_cnt <= rsp_cnt + 1;
        if (rsp_expected_q.size() == 0) begin
          $error("result word with nothing expected: time=%0h status=%0d",
                 rsp_if.predicted_time, rsp_if.status);
          err_cnt++;
        end else begin
          exp_rsp = rsp_expected_q.pop_front();
          stat_seen[exp_rsp.status] <= stat_seen[exp_rsp.status] + 1;
          if (rsp_if.predicted_time !== exp_rsp.predicted_time) begin
            $error("predicted_time: expected %0h, actual %0h",
                   exp_rsp.predicted_time, rsp_if.predicted_time);
            err_cnt++;
          end
          if (rsp_if.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_if.status);
            err_cnt++;
          end
        end
      end
      if (mon_gap > 0) begin
        mon_gap      <= mon_gap - 1;
        rsp_if.ready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 3) == 0) begin
        mon_gap      <= $urandom_range(0, 4);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    err_cnt = 0;
    rsp_cnt = 0;
    foreach (stat_seen[i]) stat_seen[i] = 0;
  end

  // Cycle limit
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results pending",
                 cycle_cnt, rsp_expected_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    @(posedge clk_i);
    while (rsp_expected_q.size() != 0 || req_if.valid) @(posedge clk_i);
    repeat (END_WAIT) @(posedge clk_i);
    if (rsp_expected_q.size() != 0) err_cnt++;
    $display("checked %0d results: ok %0d, seed %0d, drop %0d, reset %0d, degenerate %0d",
             rsp_cnt, stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3], stat_seen[4]);
    $display("final fit holds %0d points", fit_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    fit_cnt   = '0;
    fit_sx    = '0;
    fit_sy    = '0;
    fit_sxx   = '0;
    fit_sxy   = '0;
    fit_slope = '0;
    fit_icpt  = '0;
  end

endmodule
